// File: rtl/cpp_pkg.sv
package cpp_pkg;

    localparam int unsigned MIN_PAYLOAD_BYTES = 52;
    localparam logic [15:0] TUNNEL_FLAG_BIT   = 16'h0001;

    localparam int unsigned STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_MAGIC      = 5'd0;
    localparam logic [STEP_W-1:0] STEP_VERSION    = 5'd1;
    localparam logic [STEP_W-1:0] STEP_FLAGS      = 5'd4;
    localparam logic [STEP_W-1:0] STEP_LAST_LIMIT = 5'd12;
    localparam logic [STEP_W-1:0] STEP_COUNT_1    = 5'd13;
    localparam logic [STEP_W-1:0] STEP_ELEM_1     = 5'd14;
    localparam logic [STEP_W-1:0] STEP_COUNT_2    = 5'd15;
    localparam logic [STEP_W-1:0] STEP_ELEM_2     = 5'd16;
    localparam logic [STEP_W-1:0] STEP_COUNT_3    = 5'd17;
    localparam logic [STEP_W-1:0] STEP_ELEM_3     = 5'd18;
    localparam logic [STEP_W-1:0] STEP_DONE       = 5'd19;

    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MAX_PAYLOAD_BYTES = 8'd0,
        REG_MAX_LIST_ITEMS    = 8'd1,
        REG_MAGIC_WORD        = 8'd2,
        REG_FORMAT_VERSION    = 8'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        STATUS_OK          = 3'd0,
        STATUS_TOO_LARGE   = 3'd1,
        STATUS_INCOMPLETE  = 3'd2,
        STATUS_BAD_MAGIC   = 3'd3,
        STATUS_BAD_VERSION = 3'd4,
        STATUS_MALFORMED   = 3'd5
    } status_t;

    localparam logic [3:0] KIND_STATUS   = 4'd0;
    localparam logic [3:0] KIND_TUNNEL   = 4'd3;
    localparam logic [3:0] KIND_ELEM_1   = 4'd12;
    localparam logic [3:0] KIND_ELEM_2   = 4'd13;
    localparam logic [3:0] KIND_ELEM_3   = 4'd14;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_payload;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  record_kind;
        logic [63:0] record_value;
        logic [2:0]  decode_status;
        logic        last;
    } out_item_t;

    function automatic logic [3:0] step_length(input logic [STEP_W-1:0] step);
        logic [3:0] len;
        case (step)
            5'd0, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd12: len = 4'd4;
            5'd5:                                       len = 4'd8;
            default:                                    len = 4'd2;
        endcase
        return len;
    endfunction

endpackage

// File: rtl/capability_payload_parser_unit.sv
// Capability payload parser. Takes one payload byte per beat, most significant byte
// first, with end_of_payload set on the final byte, and can take a new beat in every
// clock cycle while s_ready is high. Each completed header field but the magic word,
// version and list counts, and each list element, yields one record, and the final
// byte adds a status record with last set; a consumer keeps a payload's records only
// when that status is ok. Records leave through a four-entry output queue that takes
// up to two records per beat and hands out at most one per cycle; s_ready drops while
// fewer than two queue slots are free. Configuration writes are taken at any time but
// must only be issued while no payload is in flight.
module capability_payload_parser_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  cpp_pkg::in_item_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output cpp_pkg::out_item_t                  m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cpp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [cpp_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic [31:0] max_payload_bytes_reg;
    logic [15:0] max_list_items_reg;
    logic [31:0] magic_word_reg;
    logic [15:0] format_version_reg;

    logic [31:0]                 byte_total_reg, byte_total_next;
    logic [cpp_pkg::STEP_W-1:0]  field_step_reg, field_step_next;
    logic [3:0]                  byte_in_field_reg, byte_in_field_next;
    logic [63:0]                 value_shift_reg, value_shift_next;
    logic [15:0]                 list_remaining_reg, list_remaining_next;
    logic [2:0]                  first_error_reg, first_error_next;

    cpp_pkg::out_item_t q_reg [4];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg;

    logic               accept;
    logic               pop;
    logic               field_valid;
    cpp_pkg::out_item_t field_rec;
    cpp_pkg::out_item_t status_rec;
    logic [63:0]        shifted;
    logic [3:0]         bif_inc;
    logic [2:0]         status;
    logic [1:0]         n_push;

    assign cfg_ready = 1'b1;
    assign s_ready   = (count_reg <= 3'd2);
    assign accept    = s_valid && s_ready;
    assign m_valid   = (count_reg != 3'd0);
    assign m_data    = q_reg[rd_ptr_reg];
    assign pop       = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_payload_bytes_reg <= 32'hFFFF_FFFF;
            max_list_items_reg    <= 16'hFFFF;
            magic_word_reg        <= 32'd0;
            format_version_reg    <= 16'd0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                cpp_pkg::REG_MAX_PAYLOAD_BYTES: max_payload_bytes_reg <= cfg_data;
                cpp_pkg::REG_MAX_LIST_ITEMS:    max_list_items_reg    <= cfg_data[15:0];
                cpp_pkg::REG_MAGIC_WORD:        magic_word_reg        <= cfg_data;
                cpp_pkg::REG_FORMAT_VERSION:    format_version_reg    <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        byte_total_next     = byte_total_reg;
        field_step_next     = field_step_reg;
        byte_in_field_next  = byte_in_field_reg;
        value_shift_next    = value_shift_reg;
        list_remaining_next = list_remaining_reg;
        first_error_next    = first_error_reg;
        field_valid         = 1'b0;
        field_rec           = '0;
        shifted             = {value_shift_reg[55:0], s_data.data_byte};
        bif_inc             = byte_in_field_reg + 4'd1;

        if (byte_total_reg != 32'hFFFF_FFFF) begin
            byte_total_next = byte_total_reg + 32'd1;
        end

        if (first_error_reg == cpp_pkg::STATUS_OK) begin
            if (field_step_reg >= cpp_pkg::STEP_DONE) begin
                first_error_next = cpp_pkg::STATUS_MALFORMED;
            end else if (bif_inc < cpp_pkg::step_length(field_step_reg)) begin
                value_shift_next   = shifted;
                byte_in_field_next = bif_inc;
            end else begin
                value_shift_next   = '0;
                byte_in_field_next = '0;
                if (field_step_reg == cpp_pkg::STEP_MAGIC) begin
                    if (shifted != {32'd0, magic_word_reg}) begin
                        first_error_next = cpp_pkg::STATUS_BAD_MAGIC;
                    end
                    field_step_next = cpp_pkg::STEP_VERSION;
                end else if (field_step_reg == cpp_pkg::STEP_VERSION) begin
                    if (shifted != {48'd0, format_version_reg}) begin
                        first_error_next = cpp_pkg::STATUS_BAD_VERSION;
                    end
                    field_step_next = field_step_reg + 5'd1;
                end else if (field_step_reg == cpp_pkg::STEP_FLAGS) begin
                    field_valid            = 1'b1;
                    field_rec.record_kind  = cpp_pkg::KIND_TUNNEL;
                    field_rec.record_value =
                        {63'd0, (shifted[15:0] & cpp_pkg::TUNNEL_FLAG_BIT) != 16'd0};
                    field_step_next        = field_step_reg + 5'd1;
                end else if (field_step_reg <= cpp_pkg::STEP_LAST_LIMIT) begin
                    field_valid            = 1'b1;
                    field_rec.record_kind  = field_step_reg[3:0] - 4'd1;
                    field_rec.record_value = shifted;
                    field_step_next        = field_step_reg + 5'd1;
                end else if (field_step_reg == cpp_pkg::STEP_COUNT_1
                          || field_step_reg == cpp_pkg::STEP_COUNT_2
                          || field_step_reg == cpp_pkg::STEP_COUNT_3) begin
                    if (shifted[15:0] > max_list_items_reg) begin
                        first_error_next = cpp_pkg::STATUS_MALFORMED;
                    end else if (shifted[15:0] == 16'd0) begin
                        field_step_next = field_step_reg + 5'd2;
                    end else begin
                        list_remaining_next = shifted[15:0];
                        field_step_next     = field_step_reg + 5'd1;
                    end
                end else begin
                    field_valid            = 1'b1;
                    field_rec.record_value = shifted;
                    case (field_step_reg)
                        cpp_pkg::STEP_ELEM_1: field_rec.record_kind = cpp_pkg::KIND_ELEM_1;
                        cpp_pkg::STEP_ELEM_2: field_rec.record_kind = cpp_pkg::KIND_ELEM_2;
                        default:              field_rec.record_kind = cpp_pkg::KIND_ELEM_3;
                    endcase
                    list_remaining_next = list_remaining_reg - 16'd1;
                    if (list_remaining_next == 16'd0) begin
                        field_step_next = field_step_reg + 5'd1;
                    end
                end
            end
        end

        if (byte_total_next > max_payload_bytes_reg) begin
            status = cpp_pkg::STATUS_TOO_LARGE;
        end else if (byte_total_next < 32'(cpp_pkg::MIN_PAYLOAD_BYTES)) begin
            status = cpp_pkg::STATUS_INCOMPLETE;
        end else if (first_error_next != cpp_pkg::STATUS_OK) begin
            status = first_error_next;
        end else if (field_step_next != cpp_pkg::STEP_DONE) begin
            status = cpp_pkg::STATUS_MALFORMED;
        end else begin
            status = cpp_pkg::STATUS_OK;
        end
        status_rec               = '0;
        status_rec.record_kind   = cpp_pkg::KIND_STATUS;
        status_rec.decode_status = status;
        status_rec.last          = 1'b1;

        if (s_data.end_of_payload) begin
            byte_total_next     = '0;
            field_step_next     = cpp_pkg::STEP_MAGIC;
            byte_in_field_next  = '0;
            value_shift_next    = '0;
            list_remaining_next = '0;
            first_error_next    = cpp_pkg::STATUS_OK;
        end

        n_push = accept ? ({1'b0, field_valid} + {1'b0, s_data.end_of_payload}) : 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_total_reg     <= '0;
            field_step_reg     <= cpp_pkg::STEP_MAGIC;
            byte_in_field_reg  <= '0;
            value_shift_reg    <= '0;
            list_remaining_reg <= '0;
            first_error_reg    <= cpp_pkg::STATUS_OK;
        end else if (accept) begin
            byte_total_reg     <= byte_total_next;
            field_step_reg     <= field_step_next;
            byte_in_field_reg  <= byte_in_field_next;
            value_shift_reg    <= value_shift_next;
            list_remaining_reg <= list_remaining_next;
            first_error_reg    <= first_error_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            if (field_valid) begin
                q_reg[wr_ptr_reg]        <= field_rec;
                q_reg[wr_ptr_reg + 2'd1] <= status_rec;
            end else begin
                q_reg[wr_ptr_reg]        <= status_rec;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + n_push;
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + {1'b0, n_push} - {2'b0, pop};
        end
    end

endmodule

// File: rtl/cpp_checker.sv
module cpp_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input cpp_pkg::out_item_t  m_data
);

    // A stalled result beat holds its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result beat changed");

    // Reset empties the output queue.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat present after reset");

    // An empty queue after reset leaves room for the next input beat.
    assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready after reset");

    // Only a status record closes a payload, and its status is a defined code.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.last |->
            m_data.record_kind == cpp_pkg::KIND_STATUS && m_data.record_value == 64'd0
            && m_data.decode_status <= cpp_pkg::STATUS_MALFORMED)
        else $error("malformed status record");

    // Field records carry a nonzero kind and an ok status.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last |->
            m_data.record_kind != cpp_pkg::KIND_STATUS
            && m_data.decode_status == cpp_pkg::STATUS_OK)
        else $error("malformed field record");

endmodule

bind capability_payload_parser_unit cpp_checker u_cpp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
